@@ sv/md5_pkg.sv @@
// Shared types, constants and step tables for the MD5 hash engine.
package md5_pkg;

    // Input item operations
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Initial chaining words
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    // Padding constants
    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [6:0] LEN_START  = 7'd56;
    localparam logic [6:0] BLOCK_FULL = 7'd64;
    localparam logic [6:0] BLOCK_NONE = 7'd0;

    // Step pipeline: read, pad/add constant, round; last round runs at this count
    localparam logic [6:0] FIRST_ROUND_CNT = 7'd2;
    localparam logic [6:0] LAST_ROUND_CNT  = 7'd65;

    // Round groups of the compression
    localparam logic [1:0] RND_F = 2'd0;
    localparam logic [1:0] RND_G = 2'd1;
    localparam logic [1:0] RND_H = 2'd2;
    localparam logic [1:0] RND_I = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_first_half;
        logic [63:0] digest_second_half;
    } out_item_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } work_t;

    // Additive constant of each step
    function automatic logic [31:0] md5_sine(input logic [5:0] step);
        logic [31:0] k;
        unique case (step)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Left-rotate amount of each step
    function automatic logic [4:0] md5_shift(input logic [5:0] step);
        logic [4:0] s;
        unique case ({step[5:4], step[1:0]})
            4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
            4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
            4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
            4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word used by each step
    function automatic logic [3:0] md5_word_index(input logic [5:0] step);
        logic [3:0] s;
        logic [3:0] w;
        s = step[3:0];
        unique case (step[5:4])
            RND_F:   w = s;
            RND_G:   w = s * 4'd5 + 4'd1;
            RND_H:   w = s * 4'd3 + 4'd5;
            RND_I:   w = s * 4'd7;
            default: w = s;
        endcase
        return w;
    endfunction

    // Reverse the bytes of a word
    function automatic logic [31:0] bswap32(input logic [31:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

@@ sv/md5_hash_engine.sv @@
// MD5 hash engine: byte stream in, 128-bit digest out, one shared step unit.
// An append that does not fill a block leaves the engine idle; one filling a block keeps it
//   busy through the step pipeline, the chain add and a return to idle.
// A finish runs one or two padded blocks, then loads the digest register
//   (held while a stalled digest waits) and returns to idle.
// Reset: asynchronous, active low; chaining words and byte count return to initial values.
module md5_hash_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  md5_pkg::in_item_t   item,
    output logic                digest_valid,
    input  logic                digest_stall,
    output md5_pkg::out_item_t  digest
);
    import md5_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [60:0] count_reg, count_next;
    work_t       chain_reg, chain_next;
    work_t       work_reg, work_next;
    logic [6:0]  limit_reg, limit_next;
    logic        marker_reg, marker_next;
    logic        len_en_reg, len_en_next;
    logic        second_reg, second_next;
    logic        finish_reg, finish_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg;

    // Block buffer and its read pipeline
    logic [3:0][7:0] buf_mem [16];
    logic [3:0][7:0] rd_word_reg;
    logic [3:0]      rd_addr;
    logic [3:0]      rd_addr_reg;
    logic [5:0]      rd_step_reg;
    logic [31:0]     km_reg;
    logic [5:0]      km_step_reg;
    logic [3:0][7:0] pad_word;
    logic [63:0]     len_bits;

    logic        accept;
    logic        buf_we;
    logic [5:0]  fill;
    logic        load_out;
    work_t       round_out;
    work_t       chain_sum;

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign fill         = count_reg[5:0];
    assign buf_we       = accept && (item.operation == OP_APPEND);
    assign len_bits     = {count_reg, 3'b000};
    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;

    // Write message bytes into the buffer
    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[fill[5:2]][fill[1:0]] <= item.data_byte;
        end
    end

    // Fetch the word of a later step; it reaches the round through the read and pad/add-constant registers
    assign rd_addr = md5_word_index(cnt_reg[5:0]);

    always_ff @(posedge clk)
    begin
        rd_word_reg <= buf_mem[rd_addr];
        rd_addr_reg <= rd_addr;
        rd_step_reg <= cnt_reg[5:0];
        km_reg      <= pad_word + md5_sine(rd_step_reg);
        km_step_reg <= rd_step_reg;
    end

    // Apply padding: data below the limit, marker at it, length in the last eight bytes
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            logic [6:0] pos;
            logic [2:0] len_idx;
            pos     = {1'b0, rd_addr_reg, 2'(l)};
            len_idx = {rd_addr_reg[0], 2'(l)};
            if (pos < limit_reg)
                pad_word[l] = rd_word_reg[l];
            else if (marker_reg && (pos == limit_reg))
                pad_word[l] = PAD_MARKER;
            else if (len_en_reg && (pos >= LEN_START))
                pad_word[l] = len_bits[8*len_idx +: 8];
            else
                pad_word[l] = 8'h00;
        end
    end

    md5_round u_round (
        .cur  (work_reg),
        .km   (km_reg),
        .step (km_step_reg),
        .nxt  (round_out)
    );

    // Fold the block result into the chaining words
    always_comb
    begin
        chain_sum.a = chain_reg.a + work_reg.a;
        chain_sum.b = chain_reg.b + work_reg.b;
        chain_sum.c = chain_reg.c + work_reg.c;
        chain_sum.d = chain_reg.d + work_reg.d;
    end

    // Sequence blocks, padding and digest output
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        chain_next     = chain_reg;
        work_next      = work_reg;
        limit_next     = limit_reg;
        marker_next    = marker_reg;
        len_en_next    = len_en_reg;
        second_next    = second_reg;
        finish_next    = finish_reg;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && digest_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.operation == OP_APPEND)
                    begin
                        count_next = count_reg + 61'd1;
                        if (fill == 6'd63)
                        begin
                            limit_next  = BLOCK_FULL;
                            marker_next = 1'b0;
                            len_en_next = 1'b0;
                            work_next   = chain_reg;
                            cnt_next    = 7'd0;
                            state_next  = ST_ROUND;
                        end
                    end
                    else
                    begin
                        limit_next  = {1'b0, fill};
                        marker_next = 1'b1;
                        len_en_next = ({1'b0, fill} < LEN_START);
                        second_next = ({1'b0, fill} >= LEN_START);
                        finish_next = 1'b1;
                        work_next   = chain_reg;
                        cnt_next    = 7'd0;
                        state_next  = ST_ROUND;
                    end
                end
            end

            ST_ROUND:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg >= FIRST_ROUND_CNT)
                begin
                    work_next = round_out;
                end
                if (cnt_reg == LAST_ROUND_CNT)
                begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                chain_next = chain_sum;
                if (second_reg)
                begin
                    limit_next  = BLOCK_NONE;
                    marker_next = 1'b0;
                    len_en_next = 1'b1;
                    second_next = 1'b0;
                    work_next   = chain_sum;
                    cnt_next    = 7'd0;
                    state_next  = ST_ROUND;
                end
                else if (finish_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || !digest_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    chain_next     = '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
                    count_next     = '0;
                    finish_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state and chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            count_reg     <= '0;
            chain_reg     <= '{a: INIT_A, b: INIT_B, c: INIT_C, d: INIT_D};
            limit_reg     <= '0;
            marker_reg    <= 1'b0;
            len_en_reg    <= 1'b0;
            second_reg    <= 1'b0;
            finish_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            chain_reg     <= chain_next;
            limit_reg     <= limit_next;
            marker_reg    <= marker_next;
            len_en_reg    <= len_en_next;
            second_reg    <= second_next;
            finish_reg    <= finish_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Advance working words and load the digest transaction
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        if (load_out)
        begin
            out_reg.digest_first_half  <= {bswap32(chain_reg.a), bswap32(chain_reg.b)};
            out_reg.digest_second_half <= {bswap32(chain_reg.c), bswap32(chain_reg.d)};
        end
    end

endmodule

@@ sv/md5_round.sv @@
// One MD5 compression step: mixing function, rotate and word rotation.
module md5_round (
    input  md5_pkg::work_t      cur,
    input  logic [31:0]         km,
    input  logic [5:0]          step,
    output md5_pkg::work_t      nxt
);
    import md5_pkg::*;

    logic [31:0] mix;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [4:0]  amt;

    // Select the mixing function of the round group
    always_comb
    begin
        unique case (step[5:4])
            RND_F:   mix = (cur.b & cur.c) | (~cur.b & cur.d);
            RND_G:   mix = (cur.b & cur.d) | (cur.c & ~cur.d);
            RND_H:   mix = cur.b ^ cur.c ^ cur.d;
            RND_I:   mix = cur.c ^ (cur.b | ~cur.d);
            default: mix = cur.b ^ cur.c ^ cur.d;
        endcase
    end

    // Add, rotate and shift the words along
    always_comb
    begin
        amt      = md5_shift(step);
        sum      = cur.a + mix + km;
        rot_wide = {sum, sum} << amt;
        nxt.a    = cur.d;
        nxt.b    = cur.b + rot_wide[63:32];
        nxt.c    = cur.b;
        nxt.d    = cur.c;
    end

endmodule

@@ tb/md5_digest_checker.sv @@
// Digest scoreboard: watches both channels, predicts every MD5 digest and compares it.
`timescale 1ns / 100ps

module md5_digest_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_stall,
    input  md5_pkg::in_item_t  item,
    input  logic               digest_valid,
    input  logic               digest_stall,
    input  md5_pkg::out_item_t digest,
    output int                 fail_count,
    output int                 open_digests
);

    import md5_pkg::*;

    // Additive constant of each step, step 0 in the most significant word
    localparam logic [2047:0] STEP_SINE = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, indexed by round group and step within a group of four
    localparam logic [79:0] STEP_ROT = {
        5'd7, 5'd12, 5'd17, 5'd22,  5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,  5'd6, 5'd10, 5'd15, 5'd21
    };

    logic [31:0]   chain_q [0:3];
    logic [511:0]  block_bytes;     // byte i at bits 8*i+7 .. 8*i
    logic [60:0]   msg_len;
    out_item_t     digests_due [$];
    out_item_t     want;
    int            mismatches = 0;

    // Return the chaining words and the length to their start values
    function automatic void restart_message();
        chain_q[0] = INIT_A;
        chain_q[1] = INIT_B;
        chain_q[2] = INIT_C;
        chain_q[3] = INIT_D;
        msg_len    = '0;
    endfunction

    // Run the 64-step compression of one block into the chaining words
    function automatic void compress_block(input logic [511:0] blk);
        logic [31:0] w [0:15];
        logic [31:0] a, b, c, d, f, t;
        int          i, step, g, r, sh;
        for (i = 0; i < 16; i++)
            w[i] = blk[32 * i +: 32];
        a = chain_q[0];
        b = chain_q[1];
        c = chain_q[2];
        d = chain_q[3];
        for (step = 0; step < 64; step++)
        begin
            case (step / 16)
                RND_F:   begin f = (b & c) | (~b & d); g = step;                end
                RND_G:   begin f = (b & d) | (c & ~d); g = (5 * step + 1) % 16; end
                RND_H:   begin f = b ^ c ^ d;          g = (3 * step + 5) % 16; end
                default: begin f = c ^ (b | ~d);       g = (7 * step) % 16;     end
            endcase
            r  = 4 * (step / 16) + step % 4;
            sh = STEP_ROT[5 * (15 - r) +: 5];
            t  = a + f + STEP_SINE[32 * (63 - step) +: 32] + w[g];
            t  = (t << sh) | (t >> (32 - sh));
            a  = d;
            d  = c;
            c  = b;
            b  = b + t;
        end
        chain_q[0] = chain_q[0] + a;
        chain_q[1] = chain_q[1] + b;
        chain_q[2] = chain_q[2] + c;
        chain_q[3] = chain_q[3] + d;
    endfunction

    // Absorb one accepted transaction; a finish queues the digest it must produce
    function automatic void absorb_item(input in_item_t it);
        logic [511:0] padded;
        logic [63:0]  bit_len;
        logic [5:0]   fill;
        out_item_t    result;
        int           i;
        fill = msg_len[5:0];
        if (it.operation == OP_APPEND)
        begin
            block_bytes[8 * fill +: 8] = it.data_byte;
            msg_len = msg_len + 1'b1;
            if (fill == 6'd63)
                compress_block(block_bytes);
        end
        else
        begin
            padded = '0;
            for (i = 0; i < 64; i++)
                if (i < fill)
                    padded[8 * i +: 8] = block_bytes[8 * i +: 8];
            padded[8 * fill +: 8] = PAD_MARKER;
            // no room for the length: spill into a second block
            if (fill >= LEN_START)
            begin
                compress_block(padded);
                padded = '0;
            end
            bit_len = {msg_len, 3'b000};
            padded[511 -: 64] = bit_len;
            compress_block(padded);
            for (i = 0; i < 8; i++)
            begin
                result.digest_first_half[8 * (7 - i) +: 8]  = chain_q[i / 4][8 * (i % 4) +: 8];
                result.digest_second_half[8 * (7 - i) +: 8] =
                    chain_q[2 + i / 4][8 * (i % 4) +: 8];
            end
            digests_due.push_back(result);
            restart_message();
        end
    endfunction

    // Compare digest transactions, then predict from item transactions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_message();
            digests_due.delete();
            fail_count   <= 0;
            open_digests <= 0;
        end
        else
        begin
            if (digest_valid && !digest_stall)
            begin
                if (digests_due.size() == 0)
                begin
                    $display("%0t: unexpected digest %h_%h", $time,
                             digest.digest_first_half, digest.digest_second_half);
                    mismatches++;
                end
                else
                begin
                    want = digests_due.pop_front();
                    if (digest.digest_first_half !== want.digest_first_half)
                    begin
                        $display("%0t: digest_first_half expected %h actual %h", $time,
                                 want.digest_first_half, digest.digest_first_half);
                        mismatches++;
                    end
                    if (digest.digest_second_half !== want.digest_second_half)
                    begin
                        $display("%0t: digest_second_half expected %h actual %h", $time,
                                 want.digest_second_half, digest.digest_second_half);
                        mismatches++;
                    end
                end
            end
            if (item_valid && !item_stall)
                absorb_item(item);
            fail_count   <= mismatches;
            open_digests <= digests_due.size();
        end
    end

endmodule

@@ tb/md5_hash_engine_test.sv @@
// Top of the MD5 hash engine testbench: clock, reset, message stimulus and verdict.
`timescale 1ns / 100ps

module md5_hash_engine_test;

    import md5_pkg::*;

    localparam int ITEM_TARGET    = 1150;
    localparam int MESSAGE_TARGET = 20;
    localparam int HOLD_CYCLES    = 600;
    localparam int SETTLE_CYCLES  = 300;

    // Byte patterns of a message body
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ZERO   = 1;
    localparam int FILL_ONES   = 2;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    in_item_t   item;
    logic       digest_valid;
    logic       digest_stall;
    out_item_t  digest;
    int         fail_count;
    int         open_digests;

    int         items_sent    = 0;
    int         messages_sent = 0;
    bit         burst_mode    = 1'b0;
    bit         hold_receiver = 1'b0;
    bit         steady_drain  = 1'b0;

    md5_hash_engine DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest)
    );

    md5_digest_checker digest_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest       (digest),
        .fail_count   (fail_count),
        .open_digests (open_digests)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one transaction after a random gap and hold it until accepted
    task automatic send_item(input logic op, input logic [7:0] value);
        in_item_t next;
        int       gap;
        gap = burst_mode ? 0 : $urandom_range(0, 3);
        next.operation = op;
        next.data_byte = value;
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= next;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        items_sent++;
    endtask

    // Stream a message body and close it with a finish carrying a junk byte
    task automatic send_message(input int len, input int pattern);
        logic [7:0] value;
        int         i;
        for (i = 0; i < len; i++)
        begin
            case (pattern)
                FILL_ZERO: value = 8'h00;
                FILL_ONES: value = 8'hff;
                default:   value = $urandom_range(0, 255);
            endcase
            send_item(OP_APPEND, value);
        end
        send_item(OP_FINISH, $urandom_range(0, 255));
        messages_sent++;
    endtask

    // Pause the sender until every predicted digest has come out
    task automatic drain_digests();
        item_valid <= 1'b0;
        @(posedge clk);
        while (open_digests != 0) @(posedge clk);
    endtask

    // Favor short messages and lengths around the padding and block boundaries
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(0, 12);
        else if (r < 65)
            return $urandom_range(53, 66);
        else if (r < 80)
            return $urandom_range(13, 52);
        else if (r < 90)
            return $urandom_range(113, 130);
        else
            return $urandom_range(0, 200);
    endfunction

    // Stimulus and verdict
    initial
    begin
        int  pick;
        bit  hold_done;
        hold_done  = 1'b0;
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty messages, finish byte at both extremes
        send_item(OP_FINISH, 8'hff);
        send_item(OP_FINISH, 8'h00);
        // "abc"
        send_item(OP_APPEND, 8'h61);
        send_item(OP_APPEND, 8'h62);
        send_item(OP_APPEND, 8'h63);
        send_item(OP_FINISH, 8'h5a);
        // single bytes at both extremes
        send_item(OP_APPEND, 8'h00);
        send_item(OP_FINISH, 8'ha5);
        send_item(OP_APPEND, 8'hff);
        send_item(OP_FINISH, 8'h00);
        // mixed extremes back to back
        burst_mode = 1'b1;
        send_item(OP_APPEND, 8'h00);
        send_item(OP_APPEND, 8'hff);
        send_item(OP_APPEND, 8'h80);
        send_item(OP_APPEND, 8'h7f);
        send_item(OP_FINISH, 8'hff);
        drain_digests();

        // random messages
        while (items_sent < ITEM_TARGET || messages_sent < MESSAGE_TARGET)
        begin
            // back up the output while the sender keeps pushing
            if (!hold_done && items_sent >= ITEM_TARGET / 2)
            begin
                hold_done     = 1'b1;
                hold_receiver = 1'b1;
                burst_mode    = 1'b1;
                repeat (4) send_message($urandom_range(0, 8), FILL_RANDOM);
            end
            burst_mode = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            send_message(pick_length(),
                         pick == 0 ? FILL_ZERO : (pick == 1 ? FILL_ONES : FILL_RANDOM));
            if ($urandom_range(0, 9) == 0)
                drain_digests();
        end

        drain_digests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("md5_hash_engine_test: PASS");
        else
            $display("md5_hash_engine_test: FAIL");
        $finish;
    end

    // Digest receiver: random stalls, stretches of none, one long hold-off
    initial
    begin
        int stall_cycles;
        int taken;
        taken = 0;
        digest_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_receiver)
            begin
                digest_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_receiver = 1'b0;
            end
            if (taken % 16 == 0)
                steady_drain = ($urandom_range(0, 2) == 0);
            stall_cycles = steady_drain ? 0 : $urandom_range(0, 3);
            if (stall_cycles != 0)
            begin
                digest_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            digest_stall <= 1'b0;
            @(posedge clk);
            while (!digest_valid) @(posedge clk);
            taken++;
        end
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("md5_hash_engine_test: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
sv/md5_pkg.sv
sv/md5_round.sv
sv/md5_hash_engine.sv
tb/md5_digest_checker.sv
tb/md5_hash_engine_test.sv
